/* rtl/pspm_pkg.sv */
// Shared types and constants for the packet slot pool manager.
package pspm_pkg;

  localparam int KIND_W = 3;
  localparam int SLOT_W = 6;
  localparam int AMT_W  = 12;
  localparam int FLD_W  = 12;
  localparam int USE_W  = 7;
  localparam int REF_W  = 8;
  localparam int STAT_W = 2;

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = 64;
  localparam int M_TUSER_W = STAT_W;

  typedef enum logic [KIND_W-1:0] {
    K_ALLOC  = 3'd0,
    K_REF    = 3'd1,
    K_FREE   = 3'd2,
    K_PUSH   = 3'd3,
    K_PULL   = 3'd4,
    K_APPEND = 3'd5,
    K_TRIM   = 3'd6,
    K_QUERY  = 3'd7
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_NOT_USED  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [AMT_W-1:0]  amount;
    logic              in_range;
    logic              head_ok;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot_index;
    logic [FLD_W-1:0]  data_offset;
    logic [FLD_W-1:0]  data_bytes;
    logic [FLD_W-1:0]  head_room;
    logic [FLD_W-1:0]  tail_room;
    logic              released;
    logic [USE_W-1:0]  slots_in_use;
  } res_t;

endpackage

/* rtl/pspm_front.sv */
// Request front end: unpacks the input word and classifies it for the queue.
module pspm_front #(
  parameter int SLOT_COUNT   = 64,
  parameter int BUFFER_BYTES = 2048
) (
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [pspm_pkg::S_TDATA_W-1:0] s_data_i,
  input  logic [pspm_pkg::S_TUSER_W-1:0] s_user_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output pspm_pkg::req_t                 q_data_o
);
  import pspm_pkg::*;

  localparam int DW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = ((DW > AMT_W) ? DW : AMT_W) + 1;
  localparam int NW = $clog2(SLOT_COUNT + 1);
  localparam int XW = (NW > SLOT_W) ? NW : SLOT_W;

  logic [SLOT_W-1:0] slot;
  logic [AMT_W-1:0]  amount;

  assign slot   = s_data_i[SLOT_W-1:0];
  assign amount = s_data_i[SLOT_W +: AMT_W];

  always_comb begin
    q_data_o.kind     = kind_e'(s_user_i);
    q_data_o.slot     = slot;
    q_data_o.amount   = amount;
    q_data_o.in_range = XW'(slot) < XW'(SLOT_COUNT);
    q_data_o.head_ok  = CW'(amount) <= CW'(BUFFER_BYTES);
  end

  assign q_valid_o = s_valid_i;
  assign s_ready_o = q_ready_i;

endmodule

/* rtl/pspm_queue.sv */
// Two-entry request queue between the front end and the slot engine.
module pspm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pspm_pkg::req_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output pspm_pkg::req_t pop_data_o
);
  import pspm_pkg::*;

  req_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/pspm_back.sv */
// Slot engine: slot memory, used flags, first-free search and result register.
module pspm_back #(
  parameter int SLOT_COUNT   = 64,
  parameter int BUFFER_BYTES = 2048
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  pspm_pkg::req_t q_data_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output pspm_pkg::res_t m_data_o
);
  import pspm_pkg::*;

  localparam int DW    = $clog2(BUFFER_BYTES + 1);
  localparam int CW    = ((DW > AMT_W) ? DW : AMT_W) + 1;
  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int XW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int UW    = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W = REF_W + 2 * DW;

  state_e            state_q, state_d;
  req_t              req_q;
  logic [ENT_W-1:0]  mem_q [SLOT_COUNT];
  logic [ENT_W-1:0]  rd_q;
  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [UW-1:0]     used_cnt_q, used_cnt_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  logic              out_free, pop, fire;
  logic [IDX_W-1:0]  head_idx, req_idx, free_idx, wa;
  logic              have_free, hit;
  logic [REF_W-1:0]  rd_ref, new_ref;
  logic [CW-1:0]     start_c, len_c, amt_c, buf_c, sum_c, tail_c;
  logic [CW-1:0]     new_start, new_len, new_sum, new_tail, app_off;
  logic              upd, set_used, clr_used, zero_fields, app_sel;
  status_e           status;
  res_t              res;

  assign head_idx = IDX_W'(XW'(q_data_i.slot));
  assign req_idx  = IDX_W'(XW'(req_q.slot));

  assign rd_ref  = rd_q[ENT_W-1 -: REF_W];
  assign start_c = CW'(rd_q[2*DW-1 -: DW]);
  assign len_c   = CW'(rd_q[DW-1:0]);
  assign amt_c   = CW'(req_q.amount);
  assign buf_c   = CW'(BUFFER_BYTES);
  assign sum_c   = start_c + len_c;
  assign tail_c  = (sum_c > buf_c) ? '0 : buf_c - sum_c;
  assign hit     = req_q.in_range && used_q[req_idx];

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    free_idx  = '0;
    have_free = ~&used_q;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = 1'b0;
    fire      = 1'b0;
    unique case (state_q)
      S_IDLE:  q_ready_o = 1'b1;
      S_EXEC:  fire = out_free;
      default: begin
        q_ready_o = 1'b0;
        fire      = 1'b0;
      end
    endcase
  end

  assign pop = q_valid_i && q_ready_o;

  always_comb begin
    new_start   = start_c;
    new_len     = len_c;
    new_ref     = rd_ref;
    status      = ST_OK;
    upd         = 1'b0;
    set_used    = 1'b0;
    clr_used    = 1'b0;
    zero_fields = 1'b0;
    app_sel     = 1'b0;
    wa          = req_idx;
    if (req_q.kind == K_ALLOC) begin
      wa = free_idx;
      if (!req_q.head_ok) begin
        status      = ST_REJECTED;
        zero_fields = 1'b1;
      end else if (!have_free) begin
        status      = ST_EXHAUSTED;
        zero_fields = 1'b1;
      end else begin
        set_used  = 1'b1;
        upd       = 1'b1;
        new_start = amt_c;
        new_len   = '0;
        new_ref   = REF_W'(1);
      end
    end else if (!hit) begin
      status      = ST_NOT_USED;
      zero_fields = 1'b1;
    end else begin
      unique case (req_q.kind)
        K_REF: begin
          upd = 1'b1;
          if (rd_ref != REF_MAX) begin
            new_ref = rd_ref + REF_W'(1);
          end
        end
        K_FREE: begin
          if (rd_ref > REF_W'(1)) begin
            upd     = 1'b1;
            new_ref = rd_ref - REF_W'(1);
          end else begin
            clr_used    = 1'b1;
            zero_fields = 1'b1;
          end
        end
        K_PUSH: begin
          if (amt_c > start_c) begin
            status = ST_REJECTED;
          end else begin
            upd       = 1'b1;
            new_start = start_c - amt_c;
            new_len   = len_c + amt_c;
          end
        end
        K_PULL: begin
          if (amt_c > len_c) begin
            status = ST_REJECTED;
          end else begin
            upd       = 1'b1;
            new_start = start_c + amt_c;
            new_len   = len_c - amt_c;
          end
        end
        K_APPEND: begin
          if (amt_c > tail_c) begin
            status = ST_REJECTED;
          end else begin
            upd     = 1'b1;
            app_sel = 1'b1;
            new_len = len_c + amt_c;
          end
        end
        K_TRIM: begin
          if (amt_c > len_c) begin
            status = ST_REJECTED;
          end else begin
            upd     = 1'b1;
            new_len = amt_c;
          end
        end
        default: begin
          upd = 1'b0;
        end
      endcase
    end
  end

  assign new_sum  = new_start + new_len;
  assign new_tail = (new_sum > buf_c) ? '0 : buf_c - new_sum;
  assign app_off  = sum_c;

  always_comb begin
    used_cnt_d = used_cnt_q;
    used_d     = used_q;
    if (fire && set_used) begin
      used_cnt_d     = used_cnt_q + UW'(1);
      used_d[wa]     = 1'b1;
    end else if (fire && clr_used) begin
      used_d[req_idx] = 1'b0;
      if (used_cnt_q != '0) begin
        used_cnt_d = used_cnt_q - UW'(1);
      end
    end
  end

  always_comb begin
    res              = '0;
    res.status       = status;
    res.released     = clr_used;
    res.slots_in_use = USE_W'(used_cnt_d);
    if (req_q.kind == K_ALLOC) begin
      res.slot_index = set_used ? SLOT_W'(free_idx) : '0;
    end else begin
      res.slot_index = req_q.slot;
    end
    if (!zero_fields) begin
      res.data_offset = FLD_W'(app_sel ? app_off : new_start);
      res.data_bytes  = FLD_W'(new_len);
      res.head_room   = FLD_W'(new_start);
      res.tail_room   = FLD_W'(new_tail);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      used_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      used_cnt_q  <= used_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      req_q <= q_data_i;
      rd_q  <= mem_q[head_idx];
    end
    if (fire && upd) begin
      mem_q[wa] <= {new_ref, DW'(new_start), DW'(new_len)};
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

endmodule

/* rtl/packet_slot_pool_manager.sv */
// Top level of the packet slot pool manager.
//
//   group   dir  tdata (low bit up)                                tuser
//   s_axis  in   slot[5:0] amount[17:6] zero[23:18]                kind[2:0]
//   m_axis  out  slot_index[5:0] data_offset[17:6] data_bytes[29:18]
//                head_room[41:30] tail_room[53:42] released[54]
//                slots_in_use[61:55] zero[63:62]                   status[1:0]
//
// In the slot engine each word first pops the queue and reads the slot memory,
// then updates the slot and loads the result register.
// Reset clears the used flags and count at once; no clearing pass is needed.
// A stalled result holds the engine; the two-entry queue keeps taking words until it is full.
module packet_slot_pool_manager #(
  parameter int SLOT_COUNT   = 64,
  parameter int BUFFER_BYTES = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pspm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // slot, amount
  input  logic [pspm_pkg::S_TUSER_W-1:0] s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // slot_index, data_offset, data_bytes, head_room, tail_room, released, slots_in_use
  output logic [pspm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [pspm_pkg::M_TUSER_W-1:0] m_axis_tuser   // status
);
  import pspm_pkg::*;

  logic fq_valid, fq_ready, bq_valid, bq_ready;
  req_t fq_data, bq_data;
  res_t res;

  pspm_front #(
    .SLOT_COUNT  (SLOT_COUNT),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_data_i (s_axis_tdata),
    .s_user_i (s_axis_tuser),
    .q_valid_o(fq_valid),
    .q_ready_i(fq_ready),
    .q_data_o (fq_data)
  );

  pspm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_data),
    .pop_valid_o (bq_valid),
    .pop_ready_i (bq_ready),
    .pop_data_o  (bq_data)
  );

  pspm_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(bq_valid),
    .q_ready_o(bq_ready),
    .q_data_i (bq_data),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {2'b00, res.slots_in_use, res.released, res.tail_room,
                         res.head_room, res.data_bytes, res.data_offset, res.slot_index};

endmodule

/* rtl/pspm_checker.sv */
// Port-level checker for the packet slot pool manager, bound to the top level.
module pspm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [pspm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [pspm_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pspm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [pspm_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import pspm_pkg::*;

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ (^s_axis_tuser);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EXHAUSTED) |-> m_axis_tdata[54:0] == '0)
    else $error("exhausted result carries slot data");

  a_not_used_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NOT_USED) |-> m_axis_tdata[54:6] == '0)
    else $error("not-in-use result carries slot data");

  a_release_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[54] |-> (m_axis_tuser == ST_OK) &&
                                          (m_axis_tdata[53:6] == '0))
    else $error("release result not clean");

endmodule

bind packet_slot_pool_manager pspm_checker u_pspm_checker (.*);

/* verif/tb_packet_slot_pool_manager.sv */
// Testbench for the packet slot pool manager: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module tb_packet_slot_pool_manager;
  import pspm_pkg::*;

  localparam int SLOT_COUNT   = 64;
  localparam int BUFFER_BYTES = 2048;
  localparam int IDLE_LIMIT   = 3000;
  localparam int ITEM_TOTAL   = 1050;

  typedef struct {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [AMT_W-1:0]  amount;
    bit                typed;
    res_t              want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;  // slot, amount
  logic [S_TUSER_W-1:0] s_axis_tuser;  // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // slot_index, data_offset, data_bytes, head_room, tail_room, released, slots_in_use
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;  // status

  bit               pool_used  [SLOT_COUNT];
  logic [REF_W-1:0] pool_refs  [SLOT_COUNT];
  int               pool_start [SLOT_COUNT];
  int               pool_len   [SLOT_COUNT];
  int               pool_count;

  res_t      pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  int        items_sent;
  int        results_seen;

  packet_slot_pool_manager #(
    .SLOT_COUNT  (SLOT_COUNT),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int tail_room_of(int s);
    if (pool_start[s] > BUFFER_BYTES || pool_len[s] > BUFFER_BYTES - pool_start[s]) begin
      return 0;
    end
    return BUFFER_BYTES - pool_start[s] - pool_len[s];
  endfunction

  function automatic res_t slot_view(status_e st, int s);
    res_t r;
    r = '0;
    r.status      = st;
    r.slot_index  = SLOT_W'(s);
    r.data_offset = FLD_W'(pool_start[s]);
    r.data_bytes  = FLD_W'(pool_len[s]);
    r.head_room   = FLD_W'(pool_start[s]);
    r.tail_room   = FLD_W'(tail_room_of(s));
    return r;
  endfunction

  function automatic res_t apply_pool_request(kind_e k, logic [SLOT_W-1:0] s,
                                              logic [AMT_W-1:0] a);
    res_t r;
    int   found;
    int   tail_at;
    int   sv;
    int   av;
    sv = int'(s);
    av = int'(a);
    r = '0;
    r.slot_index = s;
    found = -1;
    if (k == K_ALLOC) begin
      r.slot_index = '0;
      if (av > BUFFER_BYTES) begin
        r.status = ST_REJECTED;
      end else begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!pool_used[i] && found < 0) found = i;
        end
        if (found < 0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          pool_used[found]  = 1'b1;
          pool_refs[found]  = REF_W'(1);
          pool_start[found] = av;
          pool_len[found]   = 0;
          pool_count++;
          r = slot_view(ST_OK, found);
        end
      end
    end else if (!pool_used[sv]) begin
      r.status = ST_NOT_USED;
    end else begin
      case (k)
        K_REF: begin
          if (pool_refs[sv] != REF_MAX) pool_refs[sv]++;
          r = slot_view(ST_OK, sv);
        end
        K_FREE: begin
          if (pool_refs[sv] > REF_W'(1)) begin
            pool_refs[sv]--;
            r = slot_view(ST_OK, sv);
          end else begin
            pool_used[sv]  = 1'b0;
            pool_refs[sv]  = '0;
            pool_start[sv] = 0;
            pool_len[sv]   = 0;
            if (pool_count != 0) pool_count--;
            r.status   = ST_OK;
            r.released = 1'b1;
          end
        end
        K_PUSH: begin
          if (av > pool_start[sv]) begin
            r = slot_view(ST_REJECTED, sv);
          end else begin
            pool_start[sv] -= av;
            pool_len[sv]   += av;
            r = slot_view(ST_OK, sv);
          end
        end
        K_PULL: begin
          if (av > pool_len[sv]) begin
            r = slot_view(ST_REJECTED, sv);
          end else begin
            pool_start[sv] += av;
            pool_len[sv]   -= av;
            r = slot_view(ST_OK, sv);
          end
        end
        K_APPEND: begin
          if (av > tail_room_of(sv)) begin
            r = slot_view(ST_REJECTED, sv);
          end else begin
            tail_at = pool_start[sv] + pool_len[sv];
            pool_len[sv] += av;
            r = slot_view(ST_OK, sv);
            r.data_offset = FLD_W'(tail_at);
          end
        end
        K_TRIM: begin
          if (av > pool_len[sv]) begin
            r = slot_view(ST_REJECTED, sv);
          end else begin
            pool_len[sv] = av;
            r = slot_view(ST_OK, sv);
          end
        end
        default: begin
          r = slot_view(ST_OK, sv);
        end
      endcase
    end
    r.slots_in_use = USE_W'(pool_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_used_slot();
    int first;
    first = $urandom_range(0, SLOT_COUNT - 1);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (pool_used[(first + i) % SLOT_COUNT]) return (first + i) % SLOT_COUNT;
    end
    return first;
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount(kind_e k, int s);
    int lim;
    int r;
    case (k)
      K_ALLOC:        lim = BUFFER_BYTES;
      K_PUSH:         lim = pool_start[s];
      K_PULL, K_TRIM: lim = pool_len[s];
      K_APPEND:       lim = tail_room_of(s);
      default:        lim = 4095;
    endcase
    r = $urandom_range(0, 9);
    if (r == 0) return AMT_W'($urandom_range(0, 4095));
    if (r == 1) return AMT_W'(lim + $urandom_range(0, 1));
    if (r < 5) return AMT_W'($urandom_range(0, (lim < 16) ? lim : 16));
    return AMT_W'($urandom_range(0, lim + 2));
  endfunction

  function automatic stim_row_t mk_row(kind_e k, int s, int a);
    stim_row_t row;
    row.kind   = k;
    row.slot   = SLOT_W'(s);
    row.amount = AMT_W'(a);
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic stim_row_t mk_typed(kind_e k, int s, int a, status_e st, int idx,
                                         int off, int bytes, int head, int tail,
                                         int rel, int used);
    stim_row_t row;
    row = mk_row(k, s, a);
    row.typed             = 1'b1;
    row.want.status       = st;
    row.want.slot_index   = SLOT_W'(idx);
    row.want.data_offset  = FLD_W'(off);
    row.want.data_bytes   = FLD_W'(bytes);
    row.want.head_room    = FLD_W'(head);
    row.want.tail_room    = FLD_W'(tail);
    row.want.released     = 1'(rel);
    row.want.slots_in_use = USE_W'(used);
    return row;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("result %0d: %s got %0d, want %0d", results_seen, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string field, int got, int want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  task automatic send_word(kind_e k, logic [SLOT_W-1:0] s, logic [AMT_W-1:0] a, bit typed,
                           res_t want);
    res_t predicted;
    int   gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, a, s};
    s_axis_tuser  <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_pool_request(k, s, a);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    gap = (((items_sent / 80) % 4) == 3) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    stim_row_t row;
    kind_e     k;
    int        s;
    int        p;
    int        sat_slot;
    bit        fill_mode;
    bit        burst_done;
    bit        paused;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= K_QUERY;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool_used[i]  = 1'b0;
      pool_refs[i]  = '0;
      pool_start[i] = 0;
      pool_len[i]   = 0;
    end
    pool_count = 0;

    directed_rows.push_back(mk_typed(K_QUERY, 0, 0, ST_NOT_USED, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_typed(K_FREE, 63, 0, ST_NOT_USED, 63, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_typed(K_ALLOC, 0, 2049, ST_REJECTED, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_typed(K_ALLOC, 63, 4095, ST_REJECTED, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_typed(K_ALLOC, 0, 2048, ST_OK, 0, 2048, 0, 2048, 0, 0, 1));
    directed_rows.push_back(mk_typed(K_ALLOC, 0, 0, ST_OK, 1, 0, 0, 0, 2048, 0, 2));
    directed_rows.push_back(mk_typed(K_APPEND, 1, 2048, ST_OK, 1, 0, 2048, 0, 0, 0, 2));
    directed_rows.push_back(mk_row(K_APPEND, 1, 1));
    directed_rows.push_back(mk_row(K_PULL, 1, 2049));
    directed_rows.push_back(mk_row(K_PULL, 1, 100));
    directed_rows.push_back(mk_row(K_PUSH, 1, 101));
    directed_rows.push_back(mk_row(K_PUSH, 1, 100));
    directed_rows.push_back(mk_row(K_TRIM, 1, 4095));
    directed_rows.push_back(mk_row(K_TRIM, 1, 5));
    directed_rows.push_back(mk_row(K_PUSH, 0, 2048));
    directed_rows.push_back(mk_row(K_REF, 0, 0));
    directed_rows.push_back(mk_row(K_FREE, 0, 0));
    directed_rows.push_back(mk_typed(K_FREE, 0, 0, ST_OK, 0, 0, 0, 0, 0, 1, 1));
    directed_rows.push_back(mk_typed(K_QUERY, 0, 0, ST_NOT_USED, 0, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(mk_typed(K_REF, 5, 0, ST_NOT_USED, 5, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(mk_typed(K_PUSH, 42, 4095, ST_NOT_USED, 42, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(mk_typed(K_PULL, 33, 1, ST_NOT_USED, 33, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(mk_typed(K_APPEND, 62, 7, ST_NOT_USED, 62, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(mk_typed(K_TRIM, 21, 0, ST_NOT_USED, 21, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(mk_row(K_QUERY, 1, 4095));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.kind, row.slot, row.amount, row.typed, row.want);
    end
    drain_results();

    fill_mode  = 1'b1;
    burst_done = 1'b0;
    paused     = 1'b0;
    while (items_sent < ITEM_TOTAL) begin
      if (!burst_done && items_sent >= 400 && pool_count > 0) begin
        sat_slot = pick_used_slot();
        repeat (255) send_word(K_REF, SLOT_W'(sat_slot), AMT_W'($urandom_range(0, 4095)),
                               1'b0, '0);
        while (pool_used[sat_slot]) begin
          send_word(K_FREE, SLOT_W'(sat_slot), AMT_W'($urandom_range(0, 4095)), 1'b0, '0);
        end
        burst_done = 1'b1;
      end
      if (!paused && items_sent >= 700) begin
        drain_results();
        paused = 1'b1;
      end
      if ((items_sent % 128) == 0) fill_mode = !fill_mode;
      p = $urandom_range(0, 99);
      if (p < (fill_mode ? 40 : 8)) begin
        k = K_ALLOC;
      end else if (p < (fill_mode ? 46 : 45)) begin
        k = K_FREE;
      end else if (p < (fill_mode ? 52 : 52)) begin
        k = K_REF;
      end else begin
        k = kind_e'($urandom_range(K_PUSH, K_QUERY));
      end
      if (k == K_ALLOC || pool_count == 0 || $urandom_range(0, 9) > 7) begin
        s = $urandom_range(0, SLOT_COUNT - 1);
      end else begin
        s = pick_used_slot();
      end
      send_word(k, SLOT_W'(s), pick_amount(k, s), 1'b0, '0);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    res_t got;
    res_t want;
    int   hold_left;
    int   stall_left;
    int   mode_cycles;
    bit   quiet_mode;
    bit   held;
    hold_left   = 0;
    stall_left  = 0;
    mode_cycles = 0;
    quiet_mode  = 1'b0;
    held        = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = status_e'(m_axis_tuser);
        got.slot_index   = m_axis_tdata[5:0];
        got.data_offset  = m_axis_tdata[17:6];
        got.data_bytes   = m_axis_tdata[29:18];
        got.head_room    = m_axis_tdata[41:30];
        got.tail_room    = m_axis_tdata[53:42];
        got.released     = m_axis_tdata[54];
        got.slots_in_use = m_axis_tdata[61:55];
        if (pending_results.size() == 0) begin
          report_mismatch("word with nothing pending, slot_index", int'(got.slot_index), -1);
        end else begin
          want = pending_results.pop_front();
          check_field("status", int'(got.status), int'(want.status));
          check_field("slot_index", int'(got.slot_index), int'(want.slot_index));
          check_field("data_offset", int'(got.data_offset), int'(want.data_offset));
          check_field("data_bytes", int'(got.data_bytes), int'(want.data_bytes));
          check_field("head_room", int'(got.head_room), int'(want.head_room));
          check_field("tail_room", int'(got.tail_room), int'(want.tail_room));
          check_field("released", int'(got.released), int'(want.released));
          check_field("slots_in_use", int'(got.slots_in_use), int'(want.slots_in_use));
        end
        results_seen++;
      end
      if (!held && results_seen >= 300) begin
        held      = 1'b1;
        hold_left = 400;
      end
      mode_cycles++;
      if (mode_cycles == 150) begin
        quiet_mode  = !quiet_mode;
        mode_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = quiet_mode ? 0 : pick_gap();
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
